// ===== rtl/core/blp_pkg.sv =====
// Shared constants and types of the line plotter: defaults, request codes and inter-module structs.
package blp_pkg;

  // Default frame store geometry.
  localparam int ROW_BYTES_DEF = 32;
  localparam int ROWS_DEF      = 128;

  // Mask of the leftmost pixel within a byte.
  localparam logic [7:0] PIXEL_MASK = 8'h80;

  // Request function codes.
  localparam logic FUNC_DRAW = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // One pixel from the line walker.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] x;
    logic [6:0] y;
  } pix_t;

  // One access to the frame store; the byte address travels beside it.
  typedef struct packed {
    logic       valid;
    logic       is_read;
    logic       in_range;
    logic [7:0] mask;
  } fs_req_t;

  // Status of the frame store towards the controller.
  typedef struct packed {
    logic       clearing;
    logic       s1_busy;
    logic [7:0] rd_data;
  } fs_stat_t;

endpackage

// ===== rtl/core/blp_walker.sv =====
// Bresenham line walker that issues one pixel of the line per cycle.
module blp_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [7:0]        x_start_i,
  input  logic [6:0]        y_start_i,
  input  logic [7:0]        x_end_i,
  input  logic [6:0]        y_end_i,
  output blp_pkg::pix_t     pix_o,
  output logic [8:0]        count_o
);

  logic              active_q, active_d;
  logic [7:0]        x_q, x_d, x1_q;
  logic [6:0]        y_q, y_d, y1_q;
  logic signed [10:0] dx_q, dy_q, err_q, err_d;
  logic              sx_neg_q, sy_neg_q;
  logic [8:0]        cnt_q, cnt_d;

  logic signed [10:0] ddx, ddy, adx, ady;
  logic signed [11:0] e2;
  logic              step_x, step_y, at_end;

  // Absolute deltas of the new line, worked out at load time.
  always_comb begin
    ddx = $signed({3'b000, x_end_i}) - $signed({3'b000, x_start_i});
    ddy = $signed({4'b0000, y_end_i}) - $signed({4'b0000, y_start_i});
    adx = (ddx < 0) ? -ddx : ddx;
    ady = (ddy < 0) ? -ddy : ddy;
  end

  // Error-term decision for the current pixel.
  always_comb begin
    at_end = (x_q == x1_q) && (y_q == y1_q);
    e2     = {err_q, 1'b0};
    step_x = (e2 >= $signed({dy_q[10], dy_q}));
    step_y = (e2 <= $signed({dx_q[10], dx_q}));
  end

  // Next position, error and pixel count.
  always_comb begin
    active_d = active_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    cnt_d    = cnt_q;
    if (active_q) begin
      cnt_d = cnt_q + 9'd1;
      if (at_end) begin
        active_d = 1'b0;
      end else begin
        err_d = err_q + (step_x ? dy_q : 11'sd0) + (step_y ? dx_q : 11'sd0);
        if (step_x) begin
          x_d = sx_neg_q ? x_q - 8'd1 : x_q + 8'd1;
        end
        if (step_y) begin
          y_d = sy_neg_q ? y_q - 7'd1 : y_q + 7'd1;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (load_i) begin
      active_q <= 1'b1;
    end else begin
      active_q <= active_d;
    end
  end

  // Walker datapath registers.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q      <= x_start_i;
      y_q      <= y_start_i;
      x1_q     <= x_end_i;
      y1_q     <= y_end_i;
      dx_q     <= adx;
      dy_q     <= -ady;
      err_q    <= adx - ady;
      sx_neg_q <= !(x_start_i < x_end_i);
      sy_neg_q <= !(y_start_i < y_end_i);
      cnt_q    <= 9'd0;
    end else begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
      cnt_q <= cnt_d;
    end
  end

  assign pix_o.valid = active_q;
  assign pix_o.last  = active_q && at_end;
  assign pix_o.x     = x_q;
  assign pix_o.y     = y_q;
  assign count_o     = cnt_q;

`ifndef SYNTHESIS
  // A line never walks more pixels than the longest line holds.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cnt_q <= 9'd255))
    else $error("line walker count overran");
`endif

endmodule

// ===== rtl/core/blp_frame_store.sv =====
// Frame store memory with clearing pass, read-modify-write stage and write forwarding.
module blp_frame_store #(
  parameter int ROW_BYTES = blp_pkg::ROW_BYTES_DEF,
  parameter int ROWS      = blp_pkg::ROWS_DEF,
  localparam int Depth    = ROW_BYTES * ROWS,
  localparam int Aw       = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blp_pkg::fs_req_t   req_i,
  input  logic [Aw-1:0]      addr_i,
  output blp_pkg::fs_stat_t  stat_o
);

  logic [7:0]       mem_q [Depth];
  logic [7:0]       rdata_q;

  logic             clr_q;
  logic [Aw-1:0]    clr_addr_q;

  blp_pkg::fs_req_t s1_q;
  logic [Aw-1:0]    s1_addr_q;

  logic             lw_valid_q;
  logic [Aw-1:0]    lw_addr_q;
  logic [7:0]       lw_data_q;

  logic [7:0]       merged, new_byte, wdata;
  logic [Aw-1:0]    waddr;
  logic             we, pix_we;

  // Clearing pass: one byte a cycle from reset until the whole store is zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == Aw'(Depth - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + Aw'(1);
      end
    end
  end

  // Second stage holds the request whose read data is now arriving.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      lw_valid_q <= 1'b0;
    end else begin
      s1_q       <= req_i;
      lw_valid_q <= pix_we;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= addr_i;
    lw_addr_q <= s1_addr_q;
    lw_data_q <= new_byte;
  end

  // The write of the previous cycle is not yet seen by the read; take it from the bypass.
  always_comb begin
    merged   = (lw_valid_q && (lw_addr_q == s1_addr_q)) ? lw_data_q : rdata_q;
    new_byte = merged | s1_q.mask;
    pix_we   = s1_q.valid && !s1_q.is_read && s1_q.in_range;
    we       = clr_q || pix_we;
    waddr    = clr_q ? clr_addr_q : s1_addr_q;
    wdata    = clr_q ? 8'h00 : new_byte;
  end

  // Memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign stat_o.clearing = clr_q;
  assign stat_o.s1_busy  = s1_q.valid;
  assign stat_o.rd_data  = s1_q.in_range ? merged : 8'h00;

`ifndef SYNTHESIS
  // No request may reach the memory while the clearing pass owns the write port.
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_q.valid)
    else $error("frame store request during clearing pass");
`endif

endmodule

// ===== rtl/core/bresenham_line_plotter.sv =====
// Line plotter top level: request control, address generation and result register.
// A draw request walks its pixels and then passes the flush and done states; a read goes
// straight to the flush and done states. The result is registered as the plotter leaves the
// done state, and the next request is taken only once the plotter is idle again.
// One read-modify-write of the frame store per cycle sets the walking rate of a pixel.
// After reset the frame store is cleared one byte a cycle, ROW_BYTES*ROWS bytes
// (4096 by default), and no request is accepted until the pass is over.
module bresenham_line_plotter #(
  parameter int ROW_BYTES = blp_pkg::ROW_BYTES_DEF,
  parameter int ROWS      = blp_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] x_start_i,
  input  logic [6:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [6:0] y_end_i,
  input  logic [4:0] read_column_i,
  input  logic [6:0] read_row_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [8:0] pixels_plotted_o
);

  localparam int Depth = ROW_BYTES * ROWS;
  localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [6:0] RowBytesW = 7'(ROW_BYTES);
  localparam logic [8:0] RowsW     = 9'(ROWS);

  typedef enum logic [4:0] {
    StClear = 5'b00001,
    StIdle  = 5'b00010,
    StDraw  = 5'b00100,
    StFlush = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic              res_read_q;
  logic [7:0]        res_data_q;
  logic              out_valid_q;
  logic [7:0]        read_data_q;
  logic [8:0]        pixels_q;

  blp_pkg::pix_t     pix;
  logic [8:0]        count;
  blp_pkg::fs_req_t  req;
  blp_pkg::fs_stat_t stat;

  logic              accept, load_line, out_load;
  logic [6:0]        row_sel;
  logic [4:0]        col_sel;
  logic [14:0]       prod;
  logic [15:0]       addr_full;
  logic [Aw-1:0]     addr;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign load_line  = accept && (func_i == blp_pkg::FUNC_DRAW);
  assign out_load   = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  blp_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load_line),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .pix_o     (pix),
    .count_o   (count)
  );

  // Byte address and bounds check for either the walked pixel or the read request.
  always_comb begin
    if (state_q == StDraw) begin
      row_sel = pix.y;
      col_sel = pix.x[7:3];
    end else begin
      row_sel = read_row_i;
      col_sel = read_column_i;
    end
    prod         = 15'(row_sel) * 15'(RowBytesW);
    addr_full    = 16'(prod) + 16'(col_sel);
    addr         = addr_full[Aw-1:0];
    req.valid    = (state_q == StDraw) ? pix.valid
                                       : (accept && (func_i == blp_pkg::FUNC_READ));
    req.is_read  = (state_q != StDraw);
    req.in_range = (7'(col_sel) < RowBytesW) && (9'(row_sel) < RowsW);
    req.mask     = blp_pkg::PIXEL_MASK >> pix.x[2:0];
  end

  blp_frame_store #(
    .ROW_BYTES (ROW_BYTES),
    .ROWS      (ROWS)
  ) u_frame_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .addr_i (addr),
    .stat_o (stat)
  );

  // Request sequencing.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (!stat.clearing) state_d = StIdle;
      end
      StIdle: begin
        if (load_line) begin
          state_d = StDraw;
        end else if (accept) begin
          state_d = StFlush;
        end
      end
      StDraw: begin
        if (pix.last) state_d = StFlush;
      end
      StFlush: begin
        state_d = StDone;
      end
      StDone: begin
        if (out_load) state_d = StIdle;
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result capture and output register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_read_q <= (func_i == blp_pkg::FUNC_READ);
    end
    if (state_q == StFlush) begin
      res_data_q <= res_read_q ? stat.rd_data : 8'h00;
    end
    if (out_load) begin
      read_data_q <= res_data_q;
      pixels_q    <= res_read_q ? 9'd0 : count;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = read_data_q;
  assign pixels_plotted_o = pixels_q;

`ifndef SYNTHESIS
  // A result appears only after the request has finished in the frame store.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StDone))
    else $error("result presented outside completion");

  // The flush cycle always has the last access in the read-modify-write stage.
  a_flush_has_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |-> stat.s1_busy)
    else $error("flush without pending frame store access");
`endif

endmodule
